### hdl/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types and constants of the playfair digraph cipher.
// ----------------------------------------------------------------------------
package pf_pkg;

  localparam int LetterW = 5;
  localparam int Side    = 5;
  localparam int Cells   = Side * Side;
  localparam int SquareW = Cells * LetterW;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 45;
  localparam int PartAW   = 45;
  localparam int PartBW   = 40;
  localparam int PartCW   = 40;

  typedef logic [LetterW-1:0] letter_t;

  localparam letter_t CodeI = 5'd8;
  localparam letter_t CodeJ = 5'd9;
  localparam letter_t CodeQ = 5'd16;
  localparam letter_t CodeX = 5'd23;
  localparam letter_t CodeZ = 5'd25;

  localparam logic [CfgIdxW-1:0] CfgDecrypt = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPartA   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPartB   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgPartC   = 2'd3;

  typedef struct packed {
    letter_t letter;
    logic    end_of_text;
  } in_item_t;

  typedef struct packed {
    letter_t out_letter;
    logic    out_last;
  } out_item_t;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    last;
  } pair_t;

endpackage

### hdl/pf_prep.sv
// ----------------------------------------------------------------------------
// pf_prep
// Letter pairing with filler and padding, and a small queue of digraphs.
// ----------------------------------------------------------------------------
module pf_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pf_pkg::in_item_t in_data_i,
  output logic             pair_valid_o,
  output pf_pkg::pair_t    pair_o,
  input  logic             pair_pop_i
);
  import pf_pkg::*;

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);

  pair_t            queue_q [QDepth];
  logic [PtrW-1:0]  wr_q, rd_q, wr_d, rd_d;
  logic [PtrW:0]    count_q, count_d;
  letter_t          held_q, held_d;
  logic             held_valid_q, held_valid_d;

  letter_t          ch, fill, pad;
  pair_t            p0, p1;
  logic [1:0]       n_pairs, n_push;
  logic             accept;

  assign in_ready_o   = count_q <= (PtrW+1)'(QDepth - 2);
  assign accept       = in_valid_i && in_ready_o;
  assign pair_valid_o = count_q != '0;
  assign pair_o       = queue_q[rd_q];

  // digraph preparation
  always_comb begin
    ch           = (in_data_i.letter == CodeJ) ? CodeI : in_data_i.letter;
    fill         = (ch == CodeX) ? CodeQ : CodeX;
    pad          = (ch == CodeZ) ? CodeX : CodeZ;
    p0           = '{first: held_q, second: ch, last: in_data_i.end_of_text};
    p1           = '{first: ch, second: pad, last: 1'b1};
    n_pairs      = 2'd0;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    if (held_valid_q) begin
      if (ch == held_q) begin
        p0      = '{first: held_q, second: fill, last: 1'b0};
        n_pairs = in_data_i.end_of_text ? 2'd2 : 2'd1;
        held_valid_d = !in_data_i.end_of_text;
      end else begin
        n_pairs      = 2'd1;
        held_valid_d = 1'b0;
      end
    end else begin
      held_d = ch;
      if (in_data_i.end_of_text) begin
        p0           = p1;
        n_pairs      = 2'd1;
        held_valid_d = 1'b0;
      end else begin
        held_valid_d = 1'b1;
      end
    end
  end

  assign n_push  = accept ? n_pairs : 2'd0;
  assign wr_d    = wr_q + PtrW'(n_push);
  assign rd_d    = rd_q + PtrW'(pair_pop_i);
  assign count_d = count_q + (PtrW+1)'(n_push) - (PtrW+1)'(pair_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q         <= '0;
      rd_q         <= '0;
      count_q      <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
      if (accept) begin
        held_q       <= held_d;
        held_valid_q <= held_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < QDepth; e++) begin
      if (n_push != 2'd0 && PtrW'(e) == wr_q) begin
        queue_q[e] <= p0;
      end
      if (n_push == 2'd2 && PtrW'(e) == PtrW'(wr_q + PtrW'(1))) begin
        queue_q[e] <= p1;
      end
    end
  end

endmodule

### hdl/pf_cipher.sv
// ----------------------------------------------------------------------------
// pf_cipher
// Locates both letters of a digraph in the key square and applies the
// row, column and rectangle rules.
// ----------------------------------------------------------------------------
module pf_cipher (
  input  logic [pf_pkg::SquareW-1:0] square_i,
  input  logic                       decrypt_i,
  input  pf_pkg::pair_t              pair_i,
  output pf_pkg::letter_t            first_o,
  output pf_pkg::letter_t            second_o
);
  import pf_pkg::*;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  // lowest matching cell wins, no match lands on cell 0
  function automatic pos_t locate(logic [SquareW-1:0] sq, letter_t code);
    pos_t p;
    p = '0;
    for (int r = Side - 1; r >= 0; r--) begin
      for (int c = Side - 1; c >= 0; c--) begin
        if (sq[LetterW*(r*Side+c) +: LetterW] == code) begin
          p.row = 3'(r);
          p.col = 3'(c);
        end
      end
    end
    return p;
  endfunction

  function automatic letter_t cell_at(logic [SquareW-1:0] sq, pos_t p);
    letter_t v;
    v = '0;
    for (int r = 0; r < Side; r++) begin
      for (int c = 0; c < Side; c++) begin
        if (p.row == 3'(r) && p.col == 3'(c)) begin
          v = sq[LetterW*(r*Side+c) +: LetterW];
        end
      end
    end
    return v;
  endfunction

  function automatic logic [2:0] wrap_step(logic [2:0] v, logic dec);
    logic [3:0] s;
    s = {1'b0, v} + (dec ? 4'(Side - 1) : 4'd1);
    if (s >= 4'(Side)) begin
      s = s - 4'(Side);
    end
    return s[2:0];
  endfunction

  pos_t p1, p2, q1, q2;

  always_comb begin
    p1 = locate(square_i, pair_i.first);
    p2 = locate(square_i, pair_i.second);
    q1 = p1;
    q2 = p2;
    if (p1.row == p2.row) begin
      q1.col = wrap_step(p1.col, decrypt_i);
      q2.col = wrap_step(p2.col, decrypt_i);
    end else if (p1.col == p2.col) begin
      q1.row = wrap_step(p1.row, decrypt_i);
      q2.row = wrap_step(p2.row, decrypt_i);
    end else begin
      q1.col = p2.col;
      q2.col = p1.col;
    end
  end

  assign first_o  = cell_at(square_i, q1);
  assign second_o = cell_at(square_i, q2);

endmodule

### hdl/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher over a 5x5 key square loaded through the config port.
// ----------------------------------------------------------------------------
// Letters enter one beat per cycle and are paired into digraphs; a repeated
// letter gets an X filler (Q after X) and a lone final letter is padded with
// Z (X after Z). Each digraph is looked up and enciphered combinationally
// into an output register that then sends its two letters on consecutive
// beats, so output runs at one letter per cycle while the sink is ready and
// input at one letter per cycle except where filler or padding adds letters.
// A four-entry digraph queue sits between pairing and lookup; input stalls
// when fewer than two entries are free. Load the square and mode only while
// the block is idle.
module playfair_digraph_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pf_pkg::in_item_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pf_pkg::out_item_t           out_data_o,
  input  logic                        cfg_we_i,
  input  logic [pf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pf_pkg::CfgDataW-1:0] cfg_data_i
);
  import pf_pkg::*;

  logic              decrypt_q;
  logic [PartAW-1:0] part_a_q;
  logic [PartBW-1:0] part_b_q;
  logic [PartCW-1:0] part_c_q;

  logic    pair_valid, load;
  pair_t   pair;
  letter_t enc_first, enc_second;

  letter_t l1_q, l2_q;
  logic    last_q, full_q, phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
      part_a_q  <= '0;
      part_b_q  <= '0;
      part_c_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDecrypt: decrypt_q <= cfg_data_i[0];
        CfgPartA:   part_a_q  <= cfg_data_i[PartAW-1:0];
        CfgPartB:   part_b_q  <= cfg_data_i[PartBW-1:0];
        CfgPartC:   part_c_q  <= cfg_data_i[PartCW-1:0];
        default: begin
        end
      endcase
    end
  end

  pf_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .pair_valid_o (pair_valid),
    .pair_o       (pair),
    .pair_pop_i   (load)
  );

  pf_cipher u_cipher (
    .square_i  ({part_c_q, part_b_q, part_a_q}),
    .decrypt_i (decrypt_q),
    .pair_i    (pair),
    .first_o   (enc_first),
    .second_o  (enc_second)
  );

  // output register, two beats per digraph
  assign load = pair_valid && (!full_q || (phase_q && out_ready_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      full_q  <= 1'b1;
      phase_q <= 1'b0;
    end else if (full_q && out_ready_i) begin
      if (phase_q) begin
        full_q  <= 1'b0;
        phase_q <= 1'b0;
      end else begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      l1_q   <= enc_first;
      l2_q   <= enc_second;
      last_q <= pair.last;
    end
  end

  assign out_valid_o           = full_q;
  assign out_data_o.out_letter = phase_q ? l2_q : l1_q;
  assign out_data_o.out_last   = phase_q && last_q;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the playfair digraph cipher.
// ----------------------------------------------------------------------------
// Letters are streamed in as messages. A local model of the pairing, filler,
// padding and square lookup predicts every output letter, and a checker
// compares each output beat against the oldest prediction. Directed messages
// cover the row, column and rectangle rules, the filler and padding cases and
// the reset square. Random phases then load fresh squares and modes between
// messages, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
  import pf_pkg::*;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  playfair_digraph_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  bit                cfg_decrypt = 1'b0;
  logic [PartAW-1:0] sq_a        = '0;
  logic [PartBW-1:0] sq_b        = '0;
  logic [PartCW-1:0] sq_c        = '0;
  letter_t           pend_letter = '0;
  bit                pend_valid  = 1'b0;
  out_item_t         cipher_q[$];

  int errors        = 0;
  int random_items  = 0;
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int stall_left    = 0;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic letter_t square_cell(int n);
    if (n < 9) return sq_a[LetterW*n +: LetterW];
    if (n < 17) return sq_b[LetterW*(n-9) +: LetterW];
    return sq_c[LetterW*(n-17) +: LetterW];
  endfunction

  // first matching cell, cell 0 when the letter is missing
  function automatic int find_cell(letter_t code);
    for (int n = 0; n < Cells; n++) begin
      if (square_cell(n) == code) return n;
    end
    return 0;
  endfunction

  task automatic push_digraph(letter_t a, letter_t b, bit last);
    int        i1, i2, r1, c1, r2, c2, step, t;
    out_item_t beat;
    i1 = find_cell(a);
    i2 = find_cell(b);
    r1 = i1 / Side;
    c1 = i1 % Side;
    r2 = i2 / Side;
    c2 = i2 % Side;
    step = cfg_decrypt ? Side - 1 : 1;
    if (r1 == r2) begin
      c1 = (c1 + step) % Side;
      c2 = (c2 + step) % Side;
    end else if (c1 == c2) begin
      r1 = (r1 + step) % Side;
      r2 = (r2 + step) % Side;
    end else begin
      t  = c1;
      c1 = c2;
      c2 = t;
    end
    beat.out_letter = square_cell(r1 * Side + c1);
    beat.out_last   = 1'b0;
    cipher_q.push_back(beat);
    beat.out_letter = square_cell(r2 * Side + c2);
    beat.out_last   = last;
    cipher_q.push_back(beat);
  endtask

  task automatic predict_digraphs(in_item_t it);
    letter_t ch;
    letter_t fill;
    letter_t pad;
    ch = (it.letter == CodeJ) ? CodeI : it.letter;
    if (pend_valid) begin
      if (ch == pend_letter) begin
        fill = (ch == CodeX) ? CodeQ : CodeX;
        push_digraph(pend_letter, fill, 1'b0);
        pend_letter = ch;
      end else begin
        push_digraph(pend_letter, ch, it.end_of_text);
        pend_valid  = 1'b0;
        pend_letter = '0;
        return;
      end
    end else begin
      pend_letter = ch;
      pend_valid  = 1'b1;
    end
    if (it.end_of_text && pend_valid) begin
      pad = (pend_letter == CodeZ) ? CodeX : CodeZ;
      push_digraph(pend_letter, pad, 1'b1);
      pend_valid  = 1'b0;
      pend_letter = '0;
    end
  endtask

  task automatic report_mismatch(string what, int want, int got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected beat, letter", -1, int'(out_data.out_letter));
      end else begin
        want = cipher_q.pop_front();
        if (out_data.out_letter !== want.out_letter)
          report_mismatch("out_letter", int'(want.out_letter), int'(out_data.out_letter));
        if (out_data.out_last !== want.out_last)
          report_mismatch("out_last", int'(want.out_last), int'(out_data.out_last));
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      out_ready  <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CfgDecrypt: cfg_decrypt = value[0];
      CfgPartA:   sq_a = value[PartAW-1:0];
      CfgPartB:   sq_b = value[PartBW-1:0];
      CfgPartC:   sq_c = value[PartCW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_square(bit mode, logic [SquareW-1:0] sq);
    write_reg(CfgDecrypt, CfgDataW'(mode));
    write_reg(CfgPartA, CfgDataW'(sq[PartAW-1:0]));
    write_reg(CfgPartB, CfgDataW'(sq[PartAW +: PartBW]));
    write_reg(CfgPartC, CfgDataW'(sq[PartAW+PartBW +: PartCW]));
  endtask

  function automatic logic [SquareW-1:0] text_square(string s);
    logic [SquareW-1:0] sq;
    sq = '0;
    for (int k = 0; k < Cells; k++) sq[LetterW*k +: LetterW] = letter_t'(s[k] - 8'd65);
    return sq;
  endfunction

  // 25 distinct letters, usually without J
  function automatic logic [SquareW-1:0] random_square();
    letter_t            pool[26];
    letter_t            t;
    int                 drop, j;
    logic [SquareW-1:0] sq;
    for (int k = 0; k < 26; k++) pool[k] = letter_t'(k);
    drop = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 25)) : int'(CodeJ);
    pool[drop] = pool[25];
    pool[25]   = letter_t'(drop);
    for (int k = Cells - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      t       = pool[k];
      pool[k] = pool[j];
      pool[j] = t;
    end
    sq = '0;
    for (int k = 0; k < Cells; k++) sq[LetterW*k +: LetterW] = pool[k];
    return sq;
  endfunction

  task automatic send_letter(letter_t l, bit eot);
    in_item_t it;
    int       gap;
    it.letter      = l;
    it.end_of_text = eot;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    predict_digraphs(it);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      gap = pick_gap();
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_letter(letter_t'(s[i] - 8'd65), i == s.len() - 1);
  endtask

  task automatic send_random_message(int len);
    letter_t l, prev;
    int      r;
    prev = '0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0 && r < 30) l = prev;
      else if (r < 40) l = CodeJ;
      else if (r < 50) l = $urandom_range(0, 1) ? CodeX : CodeZ;
      else l = letter_t'($urandom_range(0, 25));
      send_letter(l, i == len - 1);
      prev = l;
      random_items++;
    end
  endtask

  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // every cell holds A after reset
  task automatic test_reset_square();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_text("AB");
    send_text("Y");
    drain_pipe();
  endtask

  task automatic test_encrypt_rules();
    load_square(1'b0, text_square("PLAYFIREXMBCDGHKNOQSTUVWZ"));
    src_idle_pct   = 30;
    sink_stall_pct = 30;
    send_text("PLIB");
    send_text("HEE");
    send_text("XX");
    send_text("ZZ");
    send_text("JI");
    send_text("A");
    send_text("Z");
    drain_pipe();
  endtask

  task automatic test_decrypt_rules();
    load_square(1'b1, text_square("PLAYFIREXMBCDGHKNOQSTUVWZ"));
    src_idle_pct   = 0;
    sink_stall_pct = 50;
    send_text("PLIBHE");
    send_text("QQ");
    drain_pipe();
  endtask

  task automatic test_extremes();
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    write_reg(CfgDecrypt, '1);
    write_reg(CfgPartA, '1);
    write_reg(CfgPartB, '1);
    write_reg(CfgPartC, '1);
    send_random_message(8);
    drain_pipe();
    write_reg(CfgDecrypt, '0);
    write_reg(CfgPartA, '0);
    write_reg(CfgPartB, '0);
    write_reg(CfgPartC, '0);
    send_random_message(6);
    drain_pipe();
    load_square(1'b1, text_square("ABCDEFGHIKLMNOPQRSTUVWXYZ"));
    send_random_message(10);
    drain_pipe();
  endtask

  task automatic test_random();
    int pick, msgs;
    while (random_items < 260) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        load_square(1'($urandom_range(0, 1)), random_square());
      end else begin
        write_reg(CfgDecrypt, CfgDataW'({$urandom, $urandom}));
        write_reg(CfgPartA, CfgDataW'({$urandom, $urandom}));
        write_reg(CfgPartB, CfgDataW'({$urandom, $urandom}));
        write_reg(CfgPartC, CfgDataW'({$urandom, $urandom}));
      end
      case ($urandom_range(0, 2))
        0:       src_idle_pct = 0;
        1:       src_idle_pct = 20;
        default: src_idle_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       sink_stall_pct = 0;
        1:       sink_stall_pct = 20;
        default: sink_stall_pct = 50;
      endcase
      msgs = $urandom_range(3, 6);
      repeat (msgs) begin
        send_random_message(($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14));
      end
      drain_pipe();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_square();
    test_encrypt_rules();
    test_decrypt_rules();
    test_extremes();
    test_random();
    if (cipher_q.size() != 0) report_mismatch("beats never seen", 0, cipher_q.size());
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
